@@ hdl/iesrc_pkg.sv @@
`timescale 1ns / 1ps

package iesrc_pkg;

    // echo request type codes
    localparam logic [7:0] TYPE_ECHO_V4 = 8'd8;
    localparam logic [7:0] TYPE_ECHO_V6 = 8'd128;

    // byte count saturates here
    localparam logic [16:0] POS_SAT = 17'd65536;
    // longest legal packet length
    localparam logic [16:0] POS_MAX_LEN = 17'd65535;
    // offsets below this on the last byte give a short packet
    localparam logic [16:0] POS_MIN_LAST = 17'd7;

    localparam logic [16:0] POS_CSUM_HI = 17'd2;
    localparam logic [16:0] POS_CSUM_LO = 17'd3;
    localparam logic [16:0] POS_SEQ_HI = 17'd6;
    localparam logic [16:0] POS_SEQ_LO = 17'd7;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_LONG = 2'd2;
    localparam logic [1:0] STAT_TYPE = 2'd3;

    // one queue entry: a completed word and, on the last byte, the packet verdict
    typedef struct packed {
        logic        word_valid;
        logic [15:0] word;
        logic        last;
        logic [1:0]  status;
        logic [15:0] sequence_value;
    } entry_t;

endpackage

@@ hdl/iesrc_front.sv @@
`timescale 1ns / 1ps

module iesrc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_packet,
    input  logic [19:0]          sent_count,
    output logic                 push,
    output iesrc_pkg::entry_t    push_data,
    input  logic                 full
);
    import iesrc_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [7:0]  pending_reg, pending_next;
    logic [15:0] seq_reg, seq_next;
    logic        type_reg, type_next;

    logic        accept;
    logic        first;
    logic        summing;
    logic [15:0] seq_now;
    logic        type_now;
    logic [7:0]  b;
    logic [1:0]  status;

    assign in_stall = full;
    assign accept = in_valid && !full;
    assign first = (pos_reg == '0);
    assign summing = (pos_reg != POS_SAT);

    assign seq_now = first ? (sent_count[15:0] + 16'd1) : seq_reg;
    assign type_now = first ? ((data_byte == TYPE_ECHO_V4) || (data_byte == TYPE_ECHO_V6))
                            : type_reg;

    // checksum field counts as zero, sequence field gets the new value
    always_comb
    begin
        b = data_byte;
        if ((pos_reg == POS_CSUM_HI) || (pos_reg == POS_CSUM_LO))
            b = 8'd0;
        else if (pos_reg == POS_SEQ_HI)
            b = seq_reg[15:8];
        else if (pos_reg == POS_SEQ_LO)
            b = seq_reg[7:0];
    end

    always_comb
    begin
        if (pos_reg < POS_MIN_LAST)
            status = STAT_SHORT;
        else if (pos_reg >= POS_MAX_LEN)
            status = STAT_LONG;
        else if (!type_now)
            status = STAT_TYPE;
        else
            status = STAT_OK;
    end

    always_comb
    begin
        push_data.word_valid = summing && (pos_reg[0] || end_of_packet);
        push_data.word = pos_reg[0] ? {pending_reg, b} : {b, 8'd0};
        push_data.last = end_of_packet;
        push_data.status = status;
        push_data.sequence_value = seq_now;
    end

    assign push = accept && (end_of_packet || (summing && pos_reg[0]));

    always_comb
    begin
        pos_next = pos_reg;
        pending_next = pending_reg;
        seq_next = seq_reg;
        type_next = type_reg;
        if (accept)
        begin
            if (end_of_packet)
            begin
                pos_next = '0;
                pending_next = '0;
                seq_next = '0;
                type_next = 1'b0;
            end
            else
            begin
                seq_next = seq_now;
                type_next = type_now;
                if (summing)
                begin
                    pos_next = pos_reg + 17'd1;
                    if (!pos_reg[0])
                        pending_next = b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            pending_reg <= '0;
            seq_reg <= '0;
            type_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            pending_reg <= pending_next;
            seq_reg <= seq_next;
            type_reg <= type_next;
        end
    end

endmodule

@@ hdl/iesrc_queue.sv @@
`timescale 1ns / 1ps

module iesrc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  iesrc_pkg::entry_t    push_data,
    output logic                 full,
    input  logic                 pop,
    output iesrc_pkg::entry_t    pop_data,
    output logic                 empty
);
    import iesrc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t mem_reg [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/iesrc_back.sv @@
`timescale 1ns / 1ps

module iesrc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  iesrc_pkg::entry_t    pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [15:0]          new_checksum,
    output logic [15:0]          new_sequence
);
    import iesrc_pkg::*;

    logic [15:0] sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg;
    logic [15:0] csum_reg;
    logic [15:0] seq_reg;

    logic [16:0] wide_sum;
    logic [15:0] sum_add;
    logic        out_free;
    logic        load;

    // end-around carry add
    assign wide_sum = {1'b0, sum_reg} + {1'b0, pop_data.word};
    assign sum_add = pop_data.word_valid
                   ? (wide_sum[16] ? wide_sum[15:0] + 16'd1 : wide_sum[15:0])
                   : sum_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop = !empty && (!pop_data.last || out_free);
    assign load = pop && pop_data.last;

    always_comb
    begin
        sum_next = sum_reg;
        if (pop)
            sum_next = pop_data.last ? '0 : sum_add;
        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= pop_data.status;
            csum_reg <= (pop_data.status == STAT_OK) ? ~sum_add : 16'd0;
            seq_reg <= pop_data.sequence_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign new_checksum = csum_reg;
    assign new_sequence = seq_reg;

endmodule

@@ hdl/icmp_echo_sequence_rewrite_checksum.sv @@
`timescale 1ns / 1ps

// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// in      | in_valid, in_stall, data_byte, end_of_packet,   | into block
//         | sent_count                                     |
// out     | out_valid, out_stall, status, new_checksum,    | out of block
//         | new_sequence                                   |
//
// one input transaction per cycle unless in_stall is high; the result for the
// transaction carrying end_of_packet passes front classify, queue, back add
// the back part folds words with a single end-around-carry adder
// the front stalls only when the entry queue is full; the back holds a
// last-byte queue head while a finished result waits under out_stall
// rst_n clears the byte counter, running sum, queue pointers and out_valid

module icmp_echo_sequence_rewrite_checksum
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic [19:0] sent_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] new_checksum,
    output logic [15:0] new_sequence
);
    import iesrc_pkg::*;

    // front to queue
    logic   push;
    entry_t push_data;
    logic   full;

    // queue to back
    logic   pop;
    entry_t pop_data;
    logic   empty;

    // front: byte offset tracking, field rewrite, word pairing, status
    iesrc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .sent_count    (sent_count),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    // short queue decouples the two sides
    iesrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // back: one's-complement accumulate and result register
    iesrc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .new_checksum (new_checksum),
        .new_sequence (new_sequence)
    );

endmodule

@@ hdl/iesrc_checker.sv @@
`timescale 1ns / 1ps

module iesrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] new_checksum,
    input logic [15:0] new_sequence
);
    import iesrc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(new_checksum) && $stable(new_sequence))
        else $error("stalled result changed");

    // faulty packets carry a zero checksum
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> new_checksum == 16'd0)
        else $error("nonzero checksum on faulty packet");

    // no result right after reset release
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind icmp_echo_sequence_rewrite_checksum iesrc_checker u_iesrc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .new_checksum (new_checksum),
    .new_sequence (new_sequence)
);

@@ tb/tb_icmp_echo_sequence_rewrite_checksum.sv @@
`timescale 1ns / 1ps

// byte stream in, one verdict per packet out
// the echo model below folds every accepted byte and queues a verdict on the
// end-of-packet byte; the result monitor pops and compares each returned transaction

module tb_icmp_echo_sequence_rewrite_checksum;

    import iesrc_pkg::*;

    // cycles with no transaction on either channel before the run is called hung
    localparam int HANG_LIMIT = 2000;
    // idle margin after the last verdict comes back
    localparam int TAIL_CYCLES = 8;

    typedef logic [7:0] frame_t [$];

    // what the block should report for one packet
    typedef struct {
        logic [1:0]  status;
        logic [15:0] checksum;
        logic [15:0] seq_no;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_packet = 1'b0;
    logic [19:0] sent_count = 20'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] new_checksum;
    logic [15:0] new_sequence;

    // idle percentages, changed only between phases with the pipeline empty
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int verdicts_checked = 0;
    int hang_cycles = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    verdict_t pending_verdicts [$];

    // echo model state, mirrors the block's per-packet registers
    logic [15:0] sum_acc = '0;
    logic [16:0] byte_pos = '0;
    logic [7:0]  pend_hi = '0;
    logic [15:0] seq_sampled = '0;
    logic        echo_seen = 1'b0;

    always #6 clk = ~clk;

    icmp_echo_sequence_rewrite_checksum u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .sent_count    (sent_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .new_checksum  (new_checksum),
        .new_sequence  (new_sequence)
    );

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        if (s > 17'h0ffff)
        begin
            s = s - 17'h0ffff;
        end
        return s[15:0];
    endfunction

    // fold one accepted byte into the echo model; queue a verdict on the last byte
    task automatic fold_echo_byte(input logic [7:0] raw, input logic eop,
                                  input logic [19:0] cnt);
        logic [7:0]  b;
        logic [16:0] len;
        verdict_t    v;
        b = raw;
        // first byte: sample the count and judge the type
        if (byte_pos == '0)
        begin
            seq_sampled = cnt[15:0] + 16'd1;
            echo_seen = (raw == TYPE_ECHO_V4) || (raw == TYPE_ECHO_V6);
        end
        // past the saturation point nothing more is summed
        if (byte_pos < POS_SAT)
        begin
            // checksum field counts as zero, sequence field is the new value
            if (byte_pos == POS_CSUM_HI || byte_pos == POS_CSUM_LO)
            begin
                b = 8'h00;
            end
            else if (byte_pos == POS_SEQ_HI)
            begin
                b = seq_sampled[15:8];
            end
            else if (byte_pos == POS_SEQ_LO)
            begin
                b = seq_sampled[7:0];
            end
            if (!byte_pos[0])
            begin
                pend_hi = b;
            end
            else
            begin
                sum_acc = ones_add(sum_acc, {pend_hi, b});
            end
            byte_pos = byte_pos + 17'd1;
        end
        if (eop)
        begin
            len = byte_pos;
            // odd length: lone byte goes in as the high half of a word
            if (len < POS_SAT && len[0])
            begin
                sum_acc = ones_add(sum_acc, {pend_hi, 8'h00});
            end
            // length faults win over a type fault
            if (len <= POS_SEQ_LO)
            begin
                v.status = STAT_SHORT;
            end
            else if (len > POS_MAX_LEN)
            begin
                v.status = STAT_LONG;
            end
            else if (!echo_seen)
            begin
                v.status = STAT_TYPE;
            end
            else
            begin
                v.status = STAT_OK;
            end
            v.checksum = (v.status == STAT_OK) ? ~sum_acc : 16'h0000;
            v.seq_no = seq_sampled;
            pending_verdicts.push_back(v);
            sum_acc = '0;
            byte_pos = '0;
            pend_hi = '0;
            seq_sampled = '0;
            echo_seen = 1'b0;
        end
    endtask

    // present one byte, hold it until accepted, then fold it into the model
    // valid is left high so back-to-back bytes need no second assignment
    task automatic send_byte(input logic [7:0] b, input logic eop, input logic [19:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_packet <= eop;
        sent_count <= cnt;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        fold_echo_byte(b, eop, cnt);
        bytes_sent++;
        if (eop)
        begin
            packets_sent++;
        end
    endtask

    // whole packet; sent_count only matters on the first byte, so the rest carry junk
    task automatic send_frame(input frame_t bytes, input logic [19:0] cnt);
        for (int i = 0; i < bytes.size(); i++)
        begin
            send_byte(bytes[i], i == bytes.size() - 1,
                      (i == 0) ? cnt : 20'($urandom_range(0, 999999)));
        end
    endtask

    // drop valid and wait until every verdict has come back
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // sum lands exactly on 0xffff, so the new checksum is zero; also count wrap
    // to sequence 0 and junk in the checksum and sequence fields
    task automatic test_checksum_rollover();
        frame_t f;
        f = '{TYPE_ECHO_V4, 8'h00, 8'hab, 8'hcd, 8'hf7, 8'hff, 8'h12, 8'h34};
        send_frame(f, 20'd65535);
    endtask

    // odd length, all-ones body, largest count
    task automatic test_odd_length();
        frame_t f;
        f.push_back(TYPE_ECHO_V6);
        repeat (8) f.push_back(8'hff);
        send_frame(f, 20'd999999);
    endtask

    // single byte, and a seven-byte packet whose bad type must not hide the short fault
    task automatic test_short_packets();
        frame_t f;
        f = '{TYPE_ECHO_V4};
        send_frame(f, 20'd0);
        f = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(f, 20'd1);
    endtask

    // minimum length with a type byte next to a legal one
    task automatic test_type_fault();
        frame_t f;
        f = '{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_frame(f, 20'd524288);
    endtask

    // mostly well-formed echo packets with random content, some short, bad type
    // and pure noise; runs until both the byte budget and a packet floor are met
    task automatic test_random_traffic(input int n_bytes, input int n_packets);
        frame_t      f;
        int          sent;
        int          pkts;
        int          len;
        int          kind;
        logic [7:0]  first;
        logic [19:0] cnt;
        sent = 0;
        pkts = 0;
        while (sent < n_bytes || pkts < n_packets)
        begin
            kind = $urandom_range(0, 99);
            f.delete();
            if (kind < 70)
            begin
                len = $urandom_range(8, 24);
                first = $urandom_range(0, 1) ? TYPE_ECHO_V4 : TYPE_ECHO_V6;
            end
            else if (kind < 80)
            begin
                len = $urandom_range(1, 7);
                first = $urandom_range(0, 1) ? TYPE_ECHO_V4 : TYPE_ECHO_V6;
            end
            else if (kind < 90)
            begin
                len = $urandom_range(8, 20);
                first = 8'($urandom_range(0, 255));
            end
            else
            begin
                len = $urandom_range(1, 40);
                first = 8'($urandom_range(0, 255));
            end
            f.push_back(first);
            // some bodies lean on 0xff to force plenty of end-around carries
            for (int i = 1; i < len; i++)
            begin
                f.push_back((kind % 5 == 0) ? 8'hff - 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0: cnt = 20'd0;
                1: cnt = 20'd999999;
                2: cnt = 20'd65535;
                default: cnt = 20'($urandom_range(0, 999999));
            endcase
            send_frame(f, cnt);
            sent += len;
            pkts++;
        end
    endtask

    // result side: random stall, compare every accepted transaction with the oldest verdict
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d checksum %h sequence %h",
                             $time, status, new_checksum, new_sequence);
                    error_count++;
                end
                else
                begin
                    v = pending_verdicts.pop_front();
                    verdicts_checked++;
                    status_seen[v.status]++;
                    if (status !== v.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, v.status, status);
                        error_count++;
                    end
                    if (new_checksum !== v.checksum)
                    begin
                        $display("%0t: checksum mismatch, expected %h, actual %h",
                                 $time, v.checksum, new_checksum);
                        error_count++;
                    end
                    if (new_sequence !== v.seq_no)
                    begin
                        $display("%0t: sequence mismatch, expected %h, actual %h",
                                 $time, v.seq_no, new_sequence);
                        error_count++;
                    end
                end
            end
        end
    end

    // hang detector: any transaction on either channel resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                hang_cycles <= 0;
            end
            else
            begin
                hang_cycles <= hang_cycles + 1;
            end
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d verdicts outstanding",
                         $time, HANG_LIMIT, pending_verdicts.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender mostly busy, receiver mostly stalling
        send_idle_pct = 23;
        recv_idle_pct = 82;
        test_checksum_rollover();
        test_odd_length();
        test_short_packets();
        test_type_fault();
        test_random_traffic(240, 16);
        settle_pipeline();

        // phase two: the other way round
        send_idle_pct = 82;
        recv_idle_pct = 23;
        test_random_traffic(230, 16);
        settle_pipeline();

        // phase three: full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(230, 16);
        settle_pipeline();

        $display("coverage: %0d packets, %0d bytes, %0d verdicts compared",
                 packets_sent, bytes_sent, verdicts_checked);
        $display("verdicts by status ok/short/long/type: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
